>>> src/dcg_pkg.sv
// Shared types and constants for the drift cluster grouper.
// Used by dcg_div and drift_cluster_grouper; depends on nothing.
package dcg_pkg;

    localparam int SLICES    = 64;
    localparam int SLICE_AW  = (SLICES > 1) ? $clog2(SLICES) : 1;
    localparam int SLOT_W    = 6;
    localparam int TIME_W    = 20;
    localparam int THR_W     = 16;
    localparam int MULT_W    = 8;
    localparam int IDX_W     = 10;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Dividend covers 255 * time + time.
    localparam int DIV_W     = 28;
    localparam int DVSR_W    = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam logic [MULT_W-1:0] MULT_MAX  = 8'd255;
    localparam logic [IDX_W-1:0]  INDEX_MAX = 10'd1023;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
    localparam logic [OP_W-1:0] OP_END    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_MODE    = 8'd1;

    localparam logic [THR_W-1:0] SLICE_WIDTH_RST = 16'd5000;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic              last;
        logic [IDX_W-1:0]  index;
        logic [MULT_W-1:0] mult;
        logic [TIME_W-1:0] time_ps;
    } t_clus_rec;

endpackage

>>> src/dcg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the threshold table; no dependencies.
module dcg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/dcg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Shared by the slice lookup and the running mean; uses dcg_pkg.
module dcg_div
    import dcg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]     r_quo;
    logic [DVSR_W-1:0]    r_rem;
    logic [DVSR_W-1:0]    r_dvsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DVSR_W:0] rem_sh;
    logic [DVSR_W:0] rem_sub;
    logic            fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvsr};
        fits    = rem_sh >= {1'b0, r_dvsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= i_req.dividend;
            r_rem  <= '0;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> src/drift_cluster_grouper.sv
// Drift cluster grouper: groups electron arrivals of one hit into clusters.
// Depends on dcg_pkg, dcg_ram (threshold table) and dcg_div (shared divider).
//
// Usage:
//   s_axis carries one request per beat: tuser is the opcode (load threshold,
//   electron arrival, end of hit), tdata the arrival time, slot and threshold.
//   m_axis carries one closed cluster per beat: tdata holds time, multiplicity
//   and index, tlast marks the cluster flushed by end of hit.
//   The cfg channel writes slice width (index 0) and average mode (index 1);
//   write it only while the block is idle. It is always ready.
// Sequence:
//   A threshold load, a first arrival, an empty end of hit or an ignored opcode
//   completes in the idle state. An arrival into an open cluster passes through
//   the divider, which forms the slice index bit-serially, then the table read
//   and the compare, and the emit step when it closes the cluster. In average
//   mode a joining arrival adds another division for the running mean. End of
//   hit with an open cluster passes through the emit step.
// Reset clears cluster state and output valid and resets the configuration;
// the threshold table holds garbage until loaded. When m_axis stalls, a
// finished cluster waits in the output register and the next request is still
// taken; only a request that must emit a second cluster waits for the slot.
module drift_cluster_grouper
    import dcg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tdata: arrival_ps[19:0], slot[25:20], threshold_ps[41:26], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode
    input  logic [OP_W-1:0]        s_axis_tuser,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: cluster_time_ps[19:0], multiplicity[27:20], cluster_index[37:28], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DAT_W-1:0]   i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SLICE = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_MEAN  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]        r_state;
    logic [DVSR_W-1:0] r_slice_w;
    logic              r_avg;
    logic [TIME_W-1:0] r_open_time;
    logic [MULT_W-1:0] r_count;
    logic [IDX_W-1:0]  r_closed;
    logic              r_open;
    logic [TIME_W-1:0] r_arrival;
    logic [SLICE_AW-1:0] r_slice;
    t_clus_rec         r_pend;
    t_clus_rec         r_out;
    logic              r_out_valid;

    logic [OP_W-1:0]   in_op;
    logic [TIME_W-1:0] in_arrival;
    logic [SLOT_W-1:0] in_slot;
    logic [THR_W-1:0]  in_thr;
    logic              in_acc;
    logic              out_free;
    logic              ram_we;
    logic [THR_W-1:0]  ram_rdata;
    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic [TIME_W-1:0] gap;
    logic              close_now;
    logic [DIV_W-1:0]  mean_sum;
    logic [SLICE_AW-1:0] slice_sat;
    logic [MULT_W-1:0] count_inc;

    assign in_arrival = s_axis_tdata[TIME_W-1:0];
    assign in_slot    = s_axis_tdata[TIME_W+SLOT_W-1:TIME_W];
    assign in_thr     = s_axis_tdata[TIME_W+SLOT_W+THR_W-1:TIME_W+SLOT_W];
    assign in_op      = s_axis_tuser;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign ram_we = in_acc && (in_op == OP_LOAD)
                    && ({1'b0, in_slot} < (SLOT_W+1)'(SLICES));

    dcg_ram #(
        .WIDTH (THR_W),
        .DEPTH (SLICES)
    ) u_thr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_slot[SLICE_AW-1:0]),
        .i_wdata (in_thr),
        .i_raddr (r_slice),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        gap       = r_arrival - r_open_time;
        close_now = (r_arrival > r_open_time) && (gap > TIME_W'(ram_rdata));
        mean_sum  = DIV_W'(r_count) * DIV_W'(r_open_time) + DIV_W'(r_arrival);
        count_inc = (r_count < MULT_MAX) ? r_count + 1'b1 : r_count;
        if (div_rsp.quotient > DIV_W'(SLICES - 1)) begin
            slice_sat = SLICE_AW'(SLICES - 1);
        end else begin
            slice_sat = div_rsp.quotient[SLICE_AW-1:0];
        end

        div_req = '0;
        if (in_acc && (in_op == OP_ARRIVE) && r_open) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(r_open_time);
            div_req.divisor  = (r_slice_w == '0) ? DVSR_W'(1) : r_slice_w;
        end else if ((r_state == S_CMP) && !close_now && r_avg) begin
            div_req.start    = 1'b1;
            div_req.dividend = mean_sum;
            div_req.divisor  = DVSR_W'(r_count) + 1'b1;
        end
    end

    dcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_w <= SLICE_WIDTH_RST;
            r_avg     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SLICE_WIDTH: r_slice_w <= i_cfg_data;
                REG_AVG_MODE:    r_avg     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control and cluster state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open_time <= '0;
            r_count     <= '0;
            r_closed    <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (in_op)
                            OP_ARRIVE: begin
                                if (!r_open) begin
                                    r_open_time <= in_arrival;
                                    r_count     <= MULT_W'(1);
                                    r_open      <= 1'b1;
                                end else begin
                                    r_state <= S_SLICE;
                                end
                            end
                            OP_END: begin
                                if (r_open) begin
                                    r_state <= S_EMIT;
                                end
                                r_open_time <= '0;
                                r_count     <= '0;
                                r_closed    <= '0;
                                r_open      <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SLICE: begin
                    if (div_rsp.done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (close_now) begin
                        if (r_closed < INDEX_MAX) begin
                            r_closed <= r_closed + 1'b1;
                        end
                        r_open_time <= r_arrival;
                        r_count     <= MULT_W'(1);
                        r_state     <= S_EMIT;
                    end else if (r_avg) begin
                        r_state <= S_MEAN;
                    end else begin
                        r_count <= count_inc;
                        r_state <= S_IDLE;
                    end
                end
                S_MEAN: begin
                    if (div_rsp.done) begin
                        r_open_time <= div_rsp.quotient[TIME_W-1:0];
                        r_count     <= count_inc;
                        r_state     <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    // hold the cluster until the output register frees up
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_arrival <= in_arrival;
        end
        if (r_state == S_SLICE && div_rsp.done) begin
            r_slice <= slice_sat;
        end
        if (in_acc && in_op == OP_END) begin
            r_pend <= '{last: 1'b1, index: r_closed, mult: r_count, time_ps: r_open_time};
        end else if (r_state == S_CMP && close_now) begin
            r_pend <= '{last: 1'b0, index: r_closed, mult: r_count, time_ps: r_open_time};
        end
        if (r_state == S_EMIT && out_free) begin
            r_out <= r_pend;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {(OUT_TDATA_W - TIME_W - MULT_W - IDX_W)'(0),
                            r_out.index, r_out.mult, r_out.time_ps};

    a_open_has_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_count != '0))
        else $error("open cluster without members");

    a_closed_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_count == '0 && r_open_time == '0))
        else $error("cluster state not cleared while no cluster is open");

    a_div_start_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_state == S_IDLE || r_state == S_CMP))
        else $error("divider started outside lookup or mean step");

    a_out_mult_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.mult != '0))
        else $error("emitted cluster with zero multiplicity");

    a_emit_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("output loaded outside emit step");

endmodule
